>>> rtl/scf_pkg.sv
package scf_pkg;

  localparam int unsigned BurstLen = 10;
  localparam int unsigned IdxW     = $clog2(BurstLen);

  localparam logic [7:0]  HeadHi      = 8'hAA;
  localparam logic [7:0]  HeadLo      = 8'h55;
  localparam logic [7:0]  TailHi      = 8'hCC;
  localparam logic [7:0]  TailLo      = 8'h33;
  localparam logic [15:0] LengthExtra = 16'd10;

  localparam logic ActBegin = 1'b0;
  localparam logic ActData  = 1'b1;

  // One input item as held in the input register.
  typedef struct packed {
    logic        action;
    logic [15:0] command;
    logic [15:0] payload_length;
    logic [7:0]  data_byte;
  } item_t;

  // Result bytes caused by one item, sent one per cycle while the output is not stalled.
  typedef struct packed {
    logic [BurstLen-1:0][7:0] bytes;
    logic [IdxW-1:0]          last_idx;
    logic                     trailer;
    logic                     error;
  } burst_t;

endpackage

>>> rtl/scf_frame_ctl.sv
module scf_frame_ctl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  scf_pkg::item_t item_i,
  input  logic           fire_i,
  output scf_pkg::burst_t burst_o
);

  logic        frame_open_q, frame_open_d;
  logic [15:0] bytes_remaining_q, bytes_remaining_d;
  logic [15:0] running_sum_q, running_sum_d;

  logic [15:0] flen;
  logic [15:0] head_sum;
  logic [15:0] data_sum;
  logic [15:0] rem_next;
  logic        seq_err;

  assign flen     = item_i.payload_length + scf_pkg::LengthExtra;
  assign head_sum = {8'h00, flen[15:8]} + {8'h00, flen[7:0]}
                  + {8'h00, item_i.command[15:8]} + {8'h00, item_i.command[7:0]};
  assign data_sum = running_sum_q + {8'h00, item_i.data_byte};
  assign rem_next = bytes_remaining_q - 16'd1;
  assign seq_err  = (item_i.action == scf_pkg::ActBegin) == frame_open_q;

  always_comb begin
    burst_o           = '0;
    frame_open_d      = frame_open_q;
    bytes_remaining_d = bytes_remaining_q;
    running_sum_d     = running_sum_q;
    if (seq_err) begin
      // drop the item, report once
      burst_o.error = 1'b1;
    end else if (item_i.action == scf_pkg::ActBegin) begin
      burst_o.bytes[0] = scf_pkg::HeadHi;
      burst_o.bytes[1] = scf_pkg::HeadLo;
      burst_o.bytes[2] = flen[15:8];
      burst_o.bytes[3] = flen[7:0];
      burst_o.bytes[4] = item_i.command[15:8];
      burst_o.bytes[5] = item_i.command[7:0];
      burst_o.last_idx = scf_pkg::IdxW'(5);
      bytes_remaining_d = item_i.payload_length;
      if (item_i.payload_length == 16'd0) begin
        burst_o.bytes[6] = head_sum[15:8];
        burst_o.bytes[7] = head_sum[7:0];
        burst_o.bytes[8] = scf_pkg::TailHi;
        burst_o.bytes[9] = scf_pkg::TailLo;
        burst_o.last_idx = scf_pkg::IdxW'(9);
        burst_o.trailer  = 1'b1;
        frame_open_d     = 1'b0;
        running_sum_d    = 16'd0;
      end else begin
        frame_open_d  = 1'b1;
        running_sum_d = head_sum;
      end
    end else begin
      burst_o.bytes[0]  = item_i.data_byte;
      bytes_remaining_d = rem_next;
      if (rem_next == 16'd0) begin
        burst_o.bytes[1] = data_sum[15:8];
        burst_o.bytes[2] = data_sum[7:0];
        burst_o.bytes[3] = scf_pkg::TailHi;
        burst_o.bytes[4] = scf_pkg::TailLo;
        burst_o.last_idx = scf_pkg::IdxW'(4);
        burst_o.trailer  = 1'b1;
        frame_open_d     = 1'b0;
        running_sum_d    = 16'd0;
      end else begin
        running_sum_d = data_sum;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_open_q      <= 1'b0;
      bytes_remaining_q <= 16'd0;
      running_sum_q     <= 16'd0;
    end else if (fire_i) begin
      frame_open_q      <= frame_open_d;
      bytes_remaining_q <= bytes_remaining_d;
      running_sum_q     <= running_sum_d;
    end
  end

endmodule

>>> rtl/scf_burst_out.sv
module scf_burst_out (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  scf_pkg::burst_t burst_i,
  output logic            load_ok_o,
  input  logic            load_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            frame_end_o,
  output logic            result_last_o,
  output logic            sequence_error_o
);

  logic                     valid_q;
  scf_pkg::burst_t          burst_q;
  logic [scf_pkg::IdxW-1:0] idx_q;
  logic                     is_last;

  assign is_last   = idx_q == burst_q.last_idx;
  assign load_ok_o = !valid_q || (is_last && !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
    end else if (valid_q && !out_stall_i) begin
      // advance through the burst, free the register after the last byte
      if (is_last) begin
        valid_q <= 1'b0;
      end
      idx_q <= idx_q + scf_pkg::IdxW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      burst_q <= burst_i;
    end
  end

  assign out_valid_o      = valid_q;
  assign out_byte_o       = burst_q.bytes[idx_q];
  assign result_last_o    = is_last;
  assign frame_end_o      = is_last && burst_q.trailer;
  assign sequence_error_o = burst_q.error;

endmodule

>>> rtl/serial_command_framer_core.sv
// Serial command framer. Each accepted item passes through an input register,
// where its result bytes and the new frame state are formed, into a burst
// register that sends one byte per cycle on the output channel while the
// output is not stalled. A payload byte in mid-frame gives one result, so
// payload flows at one item per cycle unless the output stalls; a begin item
// gives 6 bytes (10 when the payload length is zero), the last payload byte
// gives 5, and an out-of-order item gives one error result. The burst register
// sets the rate: the next item enters it in the cycle its predecessor's last
// byte is taken. An item waits in the input register while the burst is busy.
module serial_command_framer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [15:0] command_i,
  input  logic [15:0] payload_length_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        frame_end_o,
  output logic        result_last_o,
  output logic        sequence_error_o
);

  logic            in_valid_q;
  scf_pkg::item_t  item_q;
  scf_pkg::burst_t burst;
  logic            load_ok;
  logic            fire;

  assign fire       = in_valid_q && load_ok;
  assign in_stall_o = in_valid_q && !load_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q.action         <= action_i;
      item_q.command        <= command_i;
      item_q.payload_length <= payload_length_i;
      item_q.data_byte      <= data_byte_i;
    end
  end

  scf_frame_ctl u_frame_ctl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_q),
    .fire_i  (fire),
    .burst_o (burst)
  );

  scf_burst_out u_burst_out (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .burst_i          (burst),
    .load_ok_o        (load_ok),
    .load_i           (fire),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_byte_o       (out_byte_o),
    .frame_end_o      (frame_end_o),
    .result_last_o    (result_last_o),
    .sequence_error_o (sequence_error_o)
  );

  a_err_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sequence_error_o |-> result_last_o && !frame_end_o)
    else $error("error result not a single closing result");

  a_end_tail : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o |-> out_byte_o == scf_pkg::TailLo && result_last_o)
    else $error("frame end not on the last tail byte");

  a_burst_cont : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !result_last_o |=> out_valid_o)
    else $error("burst broken before its last byte");

  a_load_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && out_valid_o |-> result_last_o && !out_stall_i)
    else $error("burst register overwritten while busy");

endmodule
